### design/qnorm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// qnorm_pkg
// Shared constants and the result record of the quaternion normalizer.
// ============================================================================
package qnorm_pkg;

    localparam int LANES      = 4;      // w, x, y, z
    localparam int OUT_BITS   = 16;     // Q1.14 result width
    localparam int Q_BITS     = 15;     // quotient bits, clamped result fits
    localparam int UNIT_Q     = 16384;  // 1.0 in Q1.14
    localparam int DIV_SHIFT  = 22;     // dividend = |comp| << 22
    localparam int ROOT_SHIFT = 16;     // root taken of S << 16
    localparam int ROOT_MIN   = 256;    // smallest root for a nonzero input

    typedef struct packed {
        logic signed [OUT_BITS-1:0] w;
        logic signed [OUT_BITS-1:0] x;
        logic signed [OUT_BITS-1:0] y;
        logic signed [OUT_BITS-1:0] z;
        logic                       zero_norm;
    } qnorm_res_t;

endpackage

### design/qnorm_in_if.sv
`timescale 1ns / 1ps
// ============================================================================
// qnorm_in_if
// Input channel: one quaternion per beat, valid/ready handshake.
// ============================================================================
interface qnorm_in_if #(
    parameter int COMP_BITS = 16
) ();

    logic                        valid;
    logic                        ready;
    logic signed [COMP_BITS-1:0] in_w;
    logic signed [COMP_BITS-1:0] in_x;
    logic signed [COMP_BITS-1:0] in_y;
    logic signed [COMP_BITS-1:0] in_z;

    modport source (output valid, output in_w, output in_x, output in_y, output in_z,
                    input ready);
    modport sink   (input valid, input in_w, input in_x, input in_y, input in_z,
                    output ready);

endinterface

### design/qnorm_out_if.sv
`timescale 1ns / 1ps
// ============================================================================
// qnorm_out_if
// Output channel: one normalized quaternion per beat, valid/ready handshake.
// ============================================================================
interface qnorm_out_if
    import qnorm_pkg::*;
();

    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] out_w;
    logic signed [OUT_BITS-1:0] out_x;
    logic signed [OUT_BITS-1:0] out_y;
    logic signed [OUT_BITS-1:0] out_z;
    logic                       zero_norm;

    modport source (output valid, output out_w, output out_x, output out_y, output out_z,
                    output zero_norm, input ready);
    modport sink   (input valid, input out_w, input out_x, input out_y, input out_z,
                    input zero_norm, output ready);

endinterface

### design/quaternion_normalizer.sv
`timescale 1ns / 1ps
// ============================================================================
// quaternion_normalizer
// Scales a signed fixed-point quaternion to unit length, result in Q1.14.
// ============================================================================
// Fully pipelined: while the sink takes every result, one quaternion is
// accepted every clock and a result leaves every clock. Between the input
// beat and the output register lie four stages for magnitude, squares and
// the sum tree, COMP_BITS + 9 stages of square root at one root bit per
// stage, and 15 stages of four parallel restoring dividers at one quotient
// bit per stage. A one-entry skid register behind the output lets the pipe
// take one more beat while a result is held; after that input ready drops
// until the sink takes a result. An all-zero quaternion gives zero
// components with zero_norm set. No state is kept between beats and nothing
// needs clearing after reset.
module quaternion_normalizer
    import qnorm_pkg::*;
#(
    parameter int COMP_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    qnorm_in_if.sink     raw,
    qnorm_out_if.source  norm
);

    localparam int CB  = COMP_BITS;
    localparam int SQW = 2 * CB;                 // one square
    localparam int SW  = SQW + 1;                // sum of four squares
    localparam int VW  = SW + ROOT_SHIFT;        // root operand
    localparam int RW  = (VW + 1) / 2;           // root width
    localparam int XW  = 2 * RW + 1;             // root trial width
    localparam int DW  = CB + DIV_SHIFT;         // dividend / remainder
    localparam int CW  = RW + Q_BITS - 1;        // divider trial width
    localparam int DV0 = 4 + RW;                 // first divider stage
    localparam int NP  = DV0 + Q_BITS;           // pipe stages before output

    // ------------------------------------------------------------------
    // Pipe control: all stages move together unless the skid is full
    // ------------------------------------------------------------------
    logic          en;
    logic [NP-1:0] vld_reg;
    logic          out_vld_reg;
    logic          skid_vld_reg;

    assign en        = ~skid_vld_reg;
    assign raw.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NP-2:0], raw.valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: magnitudes and signs; side data rides along to the divider
    // ------------------------------------------------------------------
    logic [LANES-1:0][CB-1:0] raw_bits;
    logic [LANES-1:0][CB-1:0] mag_next;
    logic [LANES-1:0]         neg_next;
    logic                     zero_next;

    logic [LANES-1:0][CB-1:0] side_mag_reg  [DV0];
    logic [LANES-1:0]         side_neg_reg  [DV0];
    logic                     side_zero_reg [DV0];

    always_comb
    begin
        raw_bits[0] = raw.in_w;
        raw_bits[1] = raw.in_x;
        raw_bits[2] = raw.in_y;
        raw_bits[3] = raw.in_z;
        for (int i = 0; i < LANES; i++)
        begin
            neg_next[i] = raw_bits[i][CB-1];
            mag_next[i] = raw_bits[i][CB-1] ? (~raw_bits[i] + 1'b1) : raw_bits[i];
        end
        zero_next = ~|raw_bits;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_mag_reg[0]  <= mag_next;
            side_neg_reg[0]  <= neg_next;
            side_zero_reg[0] <= zero_next;
            for (int s = 1; s < DV0; s++)
            begin
                side_mag_reg[s]  <= side_mag_reg[s-1];
                side_neg_reg[s]  <= side_neg_reg[s-1];
                side_zero_reg[s] <= side_zero_reg[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 1..3: squares, pair sums, total
    // ------------------------------------------------------------------
    logic [LANES-1:0][SQW-1:0] sqr_next;
    logic [LANES-1:0][SQW-1:0] sqr_reg;
    logic [1:0][SQW-1:0]       pair_next;
    logic [1:0][SQW-1:0]       pair_reg;
    logic [SW-1:0]             sum_next;
    logic [SW-1:0]             sum_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            sqr_next[i] = SQW'(side_mag_reg[0][i]) * SQW'(side_mag_reg[0][i]);
        end
        // each pair is at most 2^(2*CB-1), so no carry out
        pair_next[0] = sqr_reg[0] + sqr_reg[1];
        pair_next[1] = sqr_reg[2] + sqr_reg[3];
        sum_next     = SW'(pair_reg[0]) + SW'(pair_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqr_reg  <= sqr_next;
            pair_reg <= pair_next;
            sum_reg  <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Square root of S << 16, one root bit per stage (restoring)
    // ------------------------------------------------------------------
    logic [VW-1:0] rt_rem_reg  [RW-1];
    logic [RW-1:0] rt_root_reg [RW];

    for (genvar j = 0; j < RW; j++)
    begin : g_root
        localparam int B = RW - 1 - j;

        logic [VW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [XW-1:0] rem_x;
        logic [XW-1:0] dlt;
        logic          take;
        logic [RW-1:0] root_next;

        if (j == 0)
        begin : g_first
            assign rem_in  = {sum_reg, {ROOT_SHIFT{1'b0}}};
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rt_rem_reg[j-1];
            assign root_in = rt_root_reg[j-1];
        end

        // (root + 2^B)^2 - root^2, root holds only bits above B
        assign rem_x     = XW'(rem_in);
        assign dlt       = (XW'(root_in) << (B + 1)) | (XW'(1) << (2 * B));
        assign take      = (rem_x >= dlt);
        assign root_next = take ? (root_in | (RW'(1) << B)) : root_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_root_reg[j] <= root_next;
            end
        end

        if (j < RW - 1)
        begin : g_rem
            logic [VW-1:0] rem_next;

            assign rem_next = take ? VW'(rem_x - dlt) : rem_in;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rt_rem_reg[j] <= rem_next;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Four restoring dividers, one quotient bit per stage
    // ------------------------------------------------------------------
    logic [LANES-1:0][DW-1:0]     dv_rem_reg  [Q_BITS-1];
    logic [RW-1:0]                dv_n_reg    [Q_BITS-1];
    logic [LANES-1:0][Q_BITS-1:0] dv_q_reg    [Q_BITS];
    logic [LANES-1:0]             dv_neg_reg  [Q_BITS];
    logic                         dv_zero_reg [Q_BITS];

    for (genvar k = 0; k < Q_BITS; k++)
    begin : g_div
        localparam int K = Q_BITS - 1 - k;

        logic [LANES-1:0][DW-1:0]     rem_in;
        logic [RW-1:0]                n_in;
        logic [LANES-1:0][Q_BITS-1:0] q_in;
        logic [LANES-1:0]             neg_in;
        logic                         zero_in;
        logic [CW-1:0]                trial;
        logic [LANES-1:0]             ge;
        logic [LANES-1:0][Q_BITS-1:0] q_next;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    rem_in[i] = DW'(side_mag_reg[DV0-1][i]) << DIV_SHIFT;
                end
            end
            assign n_in    = rt_root_reg[RW-1];
            assign q_in    = '0;
            assign neg_in  = side_neg_reg[DV0-1];
            assign zero_in = side_zero_reg[DV0-1];
        end
        else
        begin : g_rest
            assign rem_in  = dv_rem_reg[k-1];
            assign n_in    = dv_n_reg[k-1];
            assign q_in    = dv_q_reg[k-1];
            assign neg_in  = dv_neg_reg[k-1];
            assign zero_in = dv_zero_reg[k-1];
        end

        assign trial = CW'(n_in) << K;

        always_comb
        begin
            for (int i = 0; i < LANES; i++)
            begin
                ge[i]     = (CW'(rem_in[i]) >= trial);
                q_next[i] = ge[i] ? (q_in[i] | (Q_BITS'(1) << K)) : q_in[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_q_reg[k]    <= q_next;
                dv_neg_reg[k]  <= neg_in;
                dv_zero_reg[k] <= zero_in;
            end
        end

        if (k < Q_BITS - 1)
        begin : g_rem
            logic [LANES-1:0][DW-1:0] rem_next;

            always_comb
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    rem_next[i] = ge[i] ? DW'(CW'(rem_in[i]) - trial) : rem_in[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_rem_reg[k] <= rem_next;
                    dv_n_reg[k]   <= n_in;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Clamp, sign, and output register with one-entry skid
    // ------------------------------------------------------------------
    logic [LANES-1:0][OUT_BITS-1:0] lane_val;
    qnorm_res_t                     fmt;
    qnorm_res_t                     out_reg;
    qnorm_res_t                     out_next;
    qnorm_res_t                     skid_reg;
    qnorm_res_t                     skid_next;
    logic                           out_vld_next;
    logic                           skid_vld_next;
    logic                           arrive;
    logic                           out_free;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            logic [Q_BITS-1:0]   qc;
            logic [OUT_BITS-1:0] mg;
            // a floored root can push the quotient slightly past 1.0
            qc = (dv_q_reg[Q_BITS-1][i] > Q_BITS'(UNIT_Q)) ? Q_BITS'(UNIT_Q)
                                                             : dv_q_reg[Q_BITS-1][i];
            mg = OUT_BITS'(qc);
            if (dv_zero_reg[Q_BITS-1])
            begin
                lane_val[i] = '0;
            end
            else
            begin
                lane_val[i] = dv_neg_reg[Q_BITS-1][i] ? (~mg + 1'b1) : mg;
            end
        end
        fmt.w         = lane_val[0];
        fmt.x         = lane_val[1];
        fmt.y         = lane_val[2];
        fmt.z         = lane_val[3];
        fmt.zero_norm = dv_zero_reg[Q_BITS-1];
    end

    assign arrive   = vld_reg[NP-1] & en;
    assign out_free = ~out_vld_reg | norm.ready;

    always_comb
    begin
        out_next      = out_reg;
        skid_next     = skid_reg;
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        if (out_free)
        begin
            if (skid_vld_reg)
            begin
                out_next      = skid_reg;
                out_vld_next  = 1'b1;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_next     = fmt;
                out_vld_next = arrive;
            end
        end
        else if (arrive)
        begin
            skid_next     = fmt;
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign norm.valid     = out_vld_reg;
    assign norm.out_w     = out_reg.w;
    assign norm.out_x     = out_reg.x;
    assign norm.out_y     = out_reg.y;
    assign norm.out_z     = out_reg.z;
    assign norm.zero_norm = out_reg.zero_norm;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !norm.ready))
        else $error("skid filled while output was free");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds a beat with the output register empty");

    a_zero_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.zero_norm |->
            out_reg.w == '0 && out_reg.x == '0 && out_reg.y == '0 && out_reg.z == '0)
        else $error("zero_norm beat with nonzero components");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |->
            out_reg.w <= UNIT_Q && out_reg.w >= -UNIT_Q &&
            out_reg.x <= UNIT_Q && out_reg.x >= -UNIT_Q &&
            out_reg.y <= UNIT_Q && out_reg.y >= -UNIT_Q &&
            out_reg.z <= UNIT_Q && out_reg.z >= -UNIT_Q)
        else $error("component outside unit range");

    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DV0-1] && !side_zero_reg[DV0-1] |-> rt_root_reg[RW-1] >= RW'(ROOT_MIN))
        else $error("root too small for a nonzero quaternion");

endmodule

### test/quaternion_normalizer_test.sv
`timescale 1ns / 1ps
// ============================================================================
// quaternion_normalizer_test
// Self-checking bench for the quaternion normalizer. Quaternions go in on the
// raw channel, and each one's expected unit-length result is queued when its
// beat is accepted. Every result beat is compared field by field with the
// oldest queued result. Directed corner cases come first, then random
// traffic with idle bursts on both sides, a long output hold-off that fills
// the pipe, and a full-rate stretch at the end.
// ============================================================================
module quaternion_normalizer_test;
    import qnorm_pkg::*;

    localparam int COMP_BITS      = 16;
    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int DRAIN_CYCLES   = 64;     // pipe depth is COMP_BITS + 28
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;

    typedef logic signed [COMP_BITS-1:0] lane_t;

    typedef struct packed {
        lane_t w;
        lane_t x;
        lane_t y;
        lane_t z;
    } quat_t;

    logic clk;
    logic rst_n;

    qnorm_in_if #(.COMP_BITS(COMP_BITS)) raw_if ();
    qnorm_out_if                         norm_if ();

    quaternion_normalizer #(
        .COMP_BITS(COMP_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_if),
        .norm  (norm_if)
    );

    qnorm_res_t expected_norm[$];

    bit sender_idling;
    bit sink_idling;
    int hold_off_cycles;
    int beats_sent;
    int results_checked;
    int zero_norm_seen;
    int unit_lanes_seen;
    int input_stall_run;
    int longest_input_stall;
    int fail_count;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: unit-length quaternion in Q1.14
    // ------------------------------------------------------------------------
    function automatic qnorm_res_t predict_unit(input quat_t q);
        lane_t             comp [LANES];
        longint unsigned   mag [LANES];
        bit                negative [LANES];
        logic [OUT_BITS-1:0] lane_out [LANES];
        longint unsigned   energy;
        longint unsigned   scaled;
        longint unsigned   root;
        longint unsigned   trial;
        longint unsigned   quot;
        qnorm_res_t        res;

        comp[0] = q.w;
        comp[1] = q.x;
        comp[2] = q.y;
        comp[3] = q.z;
        energy  = 0;
        res     = '0;
        for (int i = 0; i < LANES; i++)
        begin
            negative[i] = comp[i][COMP_BITS-1];
            mag[i]      = negative[i] ? longint'(-longint'(comp[i])) : longint'(comp[i]);
            energy      = energy + mag[i] * mag[i];
        end
        if (energy == 0)
        begin
            res.zero_norm = 1'b1;
            return res;
        end
        // floor(sqrt(S << 16)); root stays below 2^25 for 16-bit lanes
        scaled = energy << ROOT_SHIFT;
        root   = 0;
        for (int b = 27; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= scaled)
                root = trial;
        end
        for (int i = 0; i < LANES; i++)
        begin
            quot = (mag[i] << DIV_SHIFT) / root;
            if (quot > UNIT_Q)
                quot = UNIT_Q;
            lane_out[i] = quot[OUT_BITS-1:0];
            if (negative[i])
                lane_out[i] = -lane_out[i];
        end
        res.w = lane_out[0];
        res.x = lane_out[1];
        res.y = lane_out[2];
        res.z = lane_out[3];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic quat_t make_quat(input int w, input int x, input int y, input int z);
        quat_t q;
        q.w = lane_t'(w);
        q.x = lane_t'(x);
        q.y = lane_t'(y);
        q.z = lane_t'(z);
        return q;
    endfunction

    function automatic lane_t pick_extreme();
        case ($urandom_range(0, 5))
            0:       return lane_t'(-32768);
            1:       return lane_t'(32767);
            2:       return lane_t'(-1);
            3:       return lane_t'(1);
            4:       return lane_t'(-32767);
            default: return lane_t'(0);
        endcase
    endfunction

    function automatic quat_t random_quaternion();
        quat_t q;
        int    big;

        q = '0;
        case ($urandom_range(0, 19)) inside
            [0:7]:
            begin
                q.w = lane_t'($urandom);
                q.x = lane_t'($urandom);
                q.y = lane_t'($urandom);
                q.z = lane_t'($urandom);
            end
            [8:10]:
            begin
                // tiny norms: few root bits, coarse quotients
                q.w = lane_t'(int'($urandom_range(0, 200)) - 100);
                q.x = lane_t'(int'($urandom_range(0, 200)) - 100);
                q.y = lane_t'(int'($urandom_range(0, 200)) - 100);
                q.z = lane_t'(int'($urandom_range(0, 200)) - 100);
            end
            [11:12]:
            begin
                q.w = pick_extreme();
                q.x = pick_extreme();
                q.y = pick_extreme();
                q.z = pick_extreme();
            end
            [13:15]:
            begin
                if ($urandom_range(0, 1)) q.w = lane_t'($urandom);
                if ($urandom_range(0, 1)) q.x = lane_t'($urandom);
                if ($urandom_range(0, 1)) q.y = lane_t'($urandom);
                if ($urandom_range(0, 1)) q.z = lane_t'($urandom);
            end
            [16:18]:
            begin
                // one dominant lane, the rest near zero: results close to unit
                q.w = lane_t'(int'($urandom_range(0, 6)) - 3);
                q.x = lane_t'(int'($urandom_range(0, 6)) - 3);
                q.y = lane_t'(int'($urandom_range(0, 6)) - 3);
                q.z = lane_t'(int'($urandom_range(0, 6)) - 3);
                big = $urandom_range(0, 1) ? int'($urandom_range(1024, 32767))
                                           : -int'($urandom_range(1024, 32768));
                case ($urandom_range(0, 3))
                    0:       q.w = lane_t'(big);
                    1:       q.x = lane_t'(big);
                    2:       q.y = lane_t'(big);
                    default: q.z = lane_t'(big);
                endcase
            end
            default:
                q = '0;
        endcase
        return q;
    endfunction

    task automatic send_quaternion(input quat_t q);
        int gap;

        if (sender_idling && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 14);
            raw_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        raw_if.valid <= 1'b1;
        raw_if.in_w  <= q.w;
        raw_if.in_x  <= q.x;
        raw_if.in_y  <= q.y;
        raw_if.in_z  <= q.z;
        do
            @(posedge clk);
        while (raw_if.ready !== 1'b1);
        expected_norm.push_back(predict_unit(q));
        beats_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_zero_quaternion();
        send_quaternion(make_quat(0, 0, 0, 0));
    endtask

    task automatic test_single_axis();
        send_quaternion(make_quat(-32768, 0, 0, 0));
        send_quaternion(make_quat(0, -32768, 0, 0));
        send_quaternion(make_quat(0, 0, -32768, 0));
        send_quaternion(make_quat(0, 0, 0, -32768));
        send_quaternion(make_quat(32767, 0, 0, 0));
        send_quaternion(make_quat(0, 32767, 0, 0));
        send_quaternion(make_quat(0, 0, 32767, 0));
        send_quaternion(make_quat(0, 0, 0, 32767));
    endtask

    task automatic test_full_scale();
        send_quaternion(make_quat(-32768, -32768, -32768, -32768));
        send_quaternion(make_quat(32767, 32767, 32767, 32767));
        send_quaternion(make_quat(32767, -32768, 32767, -32768));
        send_quaternion(make_quat(16384, -16384, 0, 16384));
    endtask

    task automatic test_tiny_norm();
        send_quaternion(make_quat(1, 0, 0, 0));
        send_quaternion(make_quat(0, 0, 0, -1));
        send_quaternion(make_quat(1, 1, 1, 1));
        send_quaternion(make_quat(-1, -1, -1, -1));
        send_quaternion(make_quat(3, -4, 0, 0));
    endtask

    task automatic test_random_traffic(input int count);
        sender_idling = 1'b1;
        sink_idling   = 1'b1;
        repeat (count) send_quaternion(random_quaternion());
    endtask

    task automatic test_output_hold_off(input int count);
        sender_idling   = 1'b0;
        sink_idling     = 1'b0;
        hold_off_cycles = HOLD_CYCLES;
        repeat (count) send_quaternion(random_quaternion());
    endtask

    task automatic test_full_rate(input int count);
        sender_idling = 1'b0;
        sink_idling   = 1'b0;
        repeat (count) send_quaternion(random_quaternion());
    endtask

    // ------------------------------------------------------------------------
    // Output ready: random stall bursts, or a long hold-off when requested
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;

        stall_left     = 0;
        norm_if.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                norm_if.ready <= 1'b0;
                hold_off_cycles--;
            end
            else if (stall_left > 0)
            begin
                norm_if.ready <= 1'b0;
                stall_left--;
            end
            else if (sink_idling && $urandom_range(0, 9) == 0)
            begin
                norm_if.ready <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end
            else
                norm_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_beat
        qnorm_res_t want;
        qnorm_res_t got;

        if (rst_n === 1'b1 && raw_if.valid === 1'b1 && raw_if.ready !== 1'b1)
        begin
            input_stall_run++;
            if (input_stall_run > longest_input_stall)
                longest_input_stall = input_stall_run;
        end
        else
            input_stall_run = 0;

        if (rst_n === 1'b1 && norm_if.valid === 1'b1 && norm_if.ready === 1'b1)
        begin
            got.w         = norm_if.out_w;
            got.x         = norm_if.out_x;
            got.y         = norm_if.out_y;
            got.z         = norm_if.out_z;
            got.zero_norm = norm_if.zero_norm;
            if (expected_norm.size() == 0)
            begin
                $error("result beat with no quaternion outstanding: w=%0d x=%0d y=%0d z=%0d",
                       got.w, got.x, got.y, got.z);
                fail_count++;
            end
            else
            begin
                want = expected_norm.pop_front();
                results_checked++;
                if (got.w !== want.w)
                begin
                    $error("out_w: expected %0d, got %0d", want.w, got.w);
                    fail_count++;
                end
                if (got.x !== want.x)
                begin
                    $error("out_x: expected %0d, got %0d", want.x, got.x);
                    fail_count++;
                end
                if (got.y !== want.y)
                begin
                    $error("out_y: expected %0d, got %0d", want.y, got.y);
                    fail_count++;
                end
                if (got.z !== want.z)
                begin
                    $error("out_z: expected %0d, got %0d", want.z, got.z);
                    fail_count++;
                end
                if (got.zero_norm !== want.zero_norm)
                begin
                    $error("zero_norm: expected %0b, got %0b", want.zero_norm, got.zero_norm);
                    fail_count++;
                end
                if (want.zero_norm)
                    zero_norm_seen++;
                if (want.w == UNIT_Q || want.w == -UNIT_Q || want.x == UNIT_Q
                    || want.x == -UNIT_Q || want.y == UNIT_Q || want.y == -UNIT_Q
                    || want.z == UNIT_Q || want.z == -UNIT_Q)
                    unit_lanes_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too many cycles with no beat on either channel
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet;

        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((raw_if.valid === 1'b1 && raw_if.ready === 1'b1)
                || (norm_if.valid === 1'b1 && norm_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_norm.size());
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           <= 1'b0;
        raw_if.valid    <= 1'b0;
        raw_if.in_w     <= '0;
        raw_if.in_x     <= '0;
        raw_if.in_y     <= '0;
        raw_if.in_z     <= '0;
        sender_idling    = 1'b0;
        sink_idling      = 1'b0;
        hold_off_cycles  = 0;
        beats_sent       = 0;
        results_checked  = 0;
        zero_norm_seen   = 0;
        unit_lanes_seen  = 0;
        input_stall_run  = 0;
        longest_input_stall = 0;
        fail_count       = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_quaternion();
        test_single_axis();
        test_full_scale();
        test_tiny_norm();
        test_random_traffic(1400);
        test_output_hold_off(150);
        test_full_rate(400);

        raw_if.valid <= 1'b0;
        while (expected_norm.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d quaternions, checked %0d results: %0d all-zero, %0d with a unit lane",
                 beats_sent, results_checked, zero_norm_seen, unit_lanes_seen);
        $display("Longest input stall under output back-pressure: %0d cycles, %0d mismatches",
                 longest_input_stall, fail_count);
        if (fail_count == 0 && expected_norm.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
